### src/rmq_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the rotation matrix to quaternion pipeline.
// No dependencies; every other file in src refers to this package by scoped names.
package rmq_pkg;

  localparam int FRAC_BITS          = 14;
  localparam int ONE_Q              = 1 << FRAC_BITS;
  localparam int DEF_SAMPLE_WIDTH   = 16;
  localparam int QUAT_WIDTH         = 16;
  localparam int QW_WIDTH           = 15;
  localparam int DIV_STEPS          = 16;
  localparam int DIV_LAT            = DIV_STEPS + 1;

  // Which quaternion component owns the square root.
  localparam logic [1:0] OWN_W = 2'd0;
  localparam logic [1:0] OWN_X = 2'd1;
  localparam logic [1:0] OWN_Y = 2'd2;
  localparam logic [1:0] OWN_Z = 2'd3;

endpackage

### src/rmq_front.sv
`timescale 1ns / 1ps
// Front end: trace, branch choice, clamped radicand and the three numerators.
// Two register stages. Depends on rmq_pkg.
module rmq_front #(
  parameter int SW = rmq_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [SW-1:0] m00_i,
  input  logic signed [SW-1:0] m01_i,
  input  logic signed [SW-1:0] m02_i,
  input  logic signed [SW-1:0] m10_i,
  input  logic signed [SW-1:0] m11_i,
  input  logic signed [SW-1:0] m12_i,
  input  logic signed [SW-1:0] m20_i,
  input  logic signed [SW-1:0] m21_i,
  input  logic signed [SW-1:0] m22_i,
  output logic                 valid_o,
  output logic [SW+2:0]        rad_o,
  output logic [1:0]           own_o,
  output logic signed [SW:0]   na_o,
  output logic signed [SW:0]   nb_o,
  output logic signed [SW:0]   nc_o
);

  localparam int RADS = SW + 4;
  localparam int RADU = SW + 3;
  localparam logic signed [RADS-1:0] ONE_R = RADS'(rmq_pkg::ONE_Q);
  localparam logic signed [RADS-1:0] ONE_LSB = RADS'(1);

  logic                 v1_q;
  logic signed [SW+1:0] t_q;
  logic                 gt01_q, gt02_q, gt12_q;
  logic signed [SW-1:0] m00_q, m11_q, m22_q;
  logic signed [SW:0]   d21_12_q, d02_20_q, d10_01_q, s01_q, s02_q, s12_q;

  function automatic logic signed [SW:0] ext1(input logic signed [SW-1:0] v);
    ext1 = {v[SW-1], v};
  endfunction

  function automatic logic signed [RADS-1:0] ext4(input logic signed [SW-1:0] v);
    ext4 = {{4{v[SW-1]}}, v};
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q      <= {{2{m00_i[SW-1]}}, m00_i} + {{2{m11_i[SW-1]}}, m11_i}
                  + {{2{m22_i[SW-1]}}, m22_i};
      gt01_q   <= m00_i > m11_i;
      gt02_q   <= m00_i > m22_i;
      gt12_q   <= m11_i > m22_i;
      m00_q    <= m00_i;
      m11_q    <= m11_i;
      m22_q    <= m22_i;
      d21_12_q <= ext1(m21_i) - ext1(m12_i);
      d02_20_q <= ext1(m02_i) - ext1(m20_i);
      d10_01_q <= ext1(m10_i) - ext1(m01_i);
      s01_q    <= ext1(m01_i) + ext1(m10_i);
      s02_q    <= ext1(m02_i) + ext1(m20_i);
      s12_q    <= ext1(m12_i) + ext1(m21_i);
    end
  end

  logic [1:0]            own_d;
  logic signed [RADS-1:0] rad_s;
  logic [RADU-1:0]       rad_d;
  logic signed [SW:0]    na_d, nb_d, nc_d;

  always_comb begin
    priority if (t_q > 0) begin
      own_d = rmq_pkg::OWN_W;
    end else if (gt01_q && gt02_q) begin
      own_d = rmq_pkg::OWN_X;
    end else if (gt12_q) begin
      own_d = rmq_pkg::OWN_Y;
    end else begin
      own_d = rmq_pkg::OWN_Z;
    end
    unique case (own_d)
      rmq_pkg::OWN_W: begin
        rad_s = {{2{t_q[SW+1]}}, t_q} + ONE_R;
        na_d  = d21_12_q;
        nb_d  = d02_20_q;
        nc_d  = d10_01_q;
      end
      rmq_pkg::OWN_X: begin
        rad_s = ONE_R + ext4(m00_q) - ext4(m11_q) - ext4(m22_q);
        na_d  = d21_12_q;
        nb_d  = s01_q;
        nc_d  = s02_q;
      end
      rmq_pkg::OWN_Y: begin
        rad_s = ONE_R + ext4(m11_q) - ext4(m00_q) - ext4(m22_q);
        na_d  = d02_20_q;
        nb_d  = s01_q;
        nc_d  = s12_q;
      end
      default: begin
        rad_s = ONE_R + ext4(m22_q) - ext4(m00_q) - ext4(m11_q);
        na_d  = d10_01_q;
        nb_d  = s02_q;
        nc_d  = s12_q;
      end
    endcase
    // A radicand below one LSB is clamped to one LSB.
    if (rad_s < ONE_LSB) begin
      rad_d = RADU'(1);
    end else begin
      rad_d = rad_s[RADU-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_o <= rad_d;
      own_o <= own_d;
      na_o  <= na_d;
      nb_o  <= nb_d;
      nc_o  <= nc_d;
    end
  end

endmodule

### src/rmq_sqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root of (rad << 14), one root bit per stage,
// with a sideband word carried alongside. Depends on rmq_pkg.
module rmq_sqrt #(
  parameter int RADU = 19,
  parameter int SBW  = 8,
  parameter int RTW  = (RADU + rmq_pkg::FRAC_BITS + 1) / 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [RADU-1:0] rad_i,
  input  logic [SBW-1:0]  side_i,
  output logic            valid_o,
  output logic [RTW-1:0]  root_o,
  output logic [SBW-1:0]  side_o
);

  localparam int NW = 2 * RTW;
  localparam logic [NW:0] ONE_B = {{NW{1'b0}}, 1'b1};

  logic            vld_q  [0:RTW];
  logic [NW:0]     rem_q  [0:RTW];
  logic [RTW-1:0]  root_q [0:RTW];
  logic [SBW-1:0]  side_q [0:RTW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= {{(NW + 1 - RADU - rmq_pkg::FRAC_BITS){1'b0}}, rad_i,
                    {rmq_pkg::FRAC_BITS{1'b0}}};
      root_q[0] <= '0;
      side_q[0] <= side_i;
    end
  end

  for (genvar s = 0; s < RTW; s++) begin : g_step
    localparam int I = RTW - 1 - s;
    logic [NW:0]    test;
    logic           ge;
    logic [NW:0]    rem_d;
    logic [RTW-1:0] root_d;

    always_comb begin
      test   = ({{(NW + 1 - RTW){1'b0}}, root_q[s]} << (I + 1)) + (ONE_B << (2 * I));
      ge     = rem_q[s] >= test;
      rem_d  = ge ? rem_q[s] - test : rem_q[s];
      root_d = root_q[s] | ({{(RTW - 1){1'b0}}, ge} << I);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1]  <= rem_d;
        root_q[s+1] <= root_d;
        side_q[s+1] <= side_q[s];
      end
    end
  end

  assign valid_o = vld_q[RTW];
  assign root_o  = root_q[RTW];
  assign side_o  = side_q[RTW];

endmodule

### src/rmq_div.sv
`timescale 1ns / 1ps
// One division lane: round((n << 14) / (2 root)) on the magnitude, restoring
// division over sixteen stages, saturated to one and signed. Depends on rmq_pkg.
module rmq_div #(
  parameter int NUMW = 17,
  parameter int RTW  = 17
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       en_i,
  input  logic                                       valid_i,
  input  logic signed [NUMW-1:0]                     num_i,
  input  logic [RTW-1:0]                             root_i,
  output logic                                       valid_o,
  output logic signed [rmq_pkg::QUAT_WIDTH-1:0]      q_o
);

  localparam int STEPS = rmq_pkg::DIV_STEPS;
  localparam int QW    = rmq_pkg::QUAT_WIDTH;
  localparam int DVW   = NUMW + rmq_pkg::FRAC_BITS + 1;
  localparam int DSW   = RTW + 1 + STEPS;
  localparam int CW    = ((DVW > DSW) ? DVW : DSW) + 1;
  localparam logic [QW-1:0] ONE_V = QW'(rmq_pkg::ONE_Q);

  logic              vld_q [0:STEPS];
  logic [CW-1:0]     rem_q [0:STEPS];
  logic [STEPS-1:0]  quo_q [0:STEPS];
  logic [RTW:0]      den_q [0:STEPS];
  logic              neg_q [0:STEPS];

  logic [NUMW-1:0] mag;
  assign mag = num_i[NUMW-1] ? NUMW'(-num_i) : num_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  // Adding the root (half the divisor) rounds the quotient to nearest.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= {{(CW - NUMW - rmq_pkg::FRAC_BITS){1'b0}}, mag,
                   {rmq_pkg::FRAC_BITS{1'b0}}} + {{(CW - RTW){1'b0}}, root_i};
      quo_q[0] <= '0;
      den_q[0] <= {root_i, 1'b0};
      neg_q[0] <= num_i[NUMW-1];
    end
  end

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    localparam int B = STEPS - 1 - s;
    logic [CW-1:0]    dsh;
    logic             ge;
    logic [CW-1:0]    rem_d;
    logic [STEPS-1:0] quo_d;

    always_comb begin
      dsh   = {{(CW - RTW - 1){1'b0}}, den_q[s]} << B;
      ge    = rem_q[s] >= dsh;
      rem_d = ge ? rem_q[s] - dsh : rem_q[s];
      quo_d = quo_q[s] | ({{(STEPS - 1){1'b0}}, ge} << B);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= rem_d;
        quo_q[s+1] <= quo_d;
        den_q[s+1] <= den_q[s];
        neg_q[s+1] <= neg_q[s];
      end
    end
  end

  // A quotient with its top bit set is already beyond one, so it saturates.
  logic [QW-1:0] qmag;
  assign qmag    = (QW'(quo_q[STEPS]) > ONE_V) ? ONE_V : QW'(quo_q[STEPS]);
  assign q_o     = neg_q[STEPS] ? -$signed(qmag) : $signed(qmag);
  assign valid_o = vld_q[STEPS];

endmodule

### src/rotation_matrix_to_quaternion.sv
`timescale 1ns / 1ps
// Pipeline: 2 front stages, RTW+1 root stages (RTW = (SAMPLE_WIDTH+18)/2, so 17 at
// the default width), 17 division stages and one output register; every stage is
// a single compare-subtract or adder. Throughput: one matrix per cycle when not stalled.
// Reset clears only the valid bits of the pipeline, the output and the skid register.
// Depends on rmq_pkg, rmq_front, rmq_sqrt and rmq_div.
module rotation_matrix_to_quaternion #(
  parameter int SAMPLE_WIDTH = rmq_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  output logic                                  stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0]        m00_i,
  input  logic signed [SAMPLE_WIDTH-1:0]        m01_i,
  input  logic signed [SAMPLE_WIDTH-1:0]        m02_i,
  input  logic signed [SAMPLE_WIDTH-1:0]        m10_i,
  input  logic signed [SAMPLE_WIDTH-1:0]        m11_i,
  input  logic signed [SAMPLE_WIDTH-1:0]        m12_i,
  input  logic signed [SAMPLE_WIDTH-1:0]        m20_i,
  input  logic signed [SAMPLE_WIDTH-1:0]        m21_i,
  input  logic signed [SAMPLE_WIDTH-1:0]        m22_i,
  output logic                                  valid_o,
  input  logic                                  stall_i,
  output logic [rmq_pkg::QW_WIDTH-1:0]          qw_o,
  output logic signed [rmq_pkg::QUAT_WIDTH-1:0] qx_o,
  output logic signed [rmq_pkg::QUAT_WIDTH-1:0] qy_o,
  output logic signed [rmq_pkg::QUAT_WIDTH-1:0] qz_o
);

  // The data path is a chain of fixed-length stages that all advance together.
  // It moves whenever the skid register is empty, so a result can sit in the
  // output register under stall while the next beat is still accepted; the
  // skid register catches the one beat that arrives in that cycle and then
  // holds the whole pipeline until the output side drains it.

  localparam int SW   = SAMPLE_WIDTH;
  localparam int NUMW = SW + 1;
  localparam int RADU = SW + 3;
  localparam int RTW  = (RADU + rmq_pkg::FRAC_BITS + 1) / 2;
  localparam int QW   = rmq_pkg::QUAT_WIDTH;
  localparam int LAT  = rmq_pkg::DIV_LAT;
  localparam int SBW  = 2 + 3 * NUMW;
  localparam logic [RTW-1:0] ONE_RT = RTW'(rmq_pkg::ONE_Q);
  localparam logic [QW-1:0]  ONE_V  = QW'(rmq_pkg::ONE_Q);

  typedef struct packed {
    logic [rmq_pkg::QW_WIDTH-1:0] qw;
    logic signed [QW-1:0]         qx;
    logic signed [QW-1:0]         qy;
    logic signed [QW-1:0]         qz;
  } quat_t;

  logic adv;
  logic skid_v_q;
  assign adv     = !skid_v_q;
  assign stall_o = skid_v_q;

  // Front end: trace, branch and numerators.
  logic                 fr_v;
  logic [RADU-1:0]      fr_rad;
  logic [1:0]           fr_own;
  logic signed [SW:0]   fr_na, fr_nb, fr_nc;

  rmq_front #(.SW(SW)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (valid_i),
    .m00_i   (m00_i),
    .m01_i   (m01_i),
    .m02_i   (m02_i),
    .m10_i   (m10_i),
    .m11_i   (m11_i),
    .m12_i   (m12_i),
    .m20_i   (m20_i),
    .m21_i   (m21_i),
    .m22_i   (m22_i),
    .valid_o (fr_v),
    .rad_o   (fr_rad),
    .own_o   (fr_own),
    .na_o    (fr_na),
    .nb_o    (fr_nb),
    .nc_o    (fr_nc)
  );

  // Square root, with the branch code and numerators riding along.
  logic            sq_v;
  logic [RTW-1:0]  sq_root;
  logic [SBW-1:0]  sq_side;

  rmq_sqrt #(.RADU(RADU), .SBW(SBW), .RTW(RTW)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (fr_v),
    .rad_i   (fr_rad),
    .side_i  ({fr_own, fr_na, fr_nb, fr_nc}),
    .valid_o (sq_v),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  logic [1:0]             sq_own;
  logic signed [NUMW-1:0] sq_na, sq_nb, sq_nc;
  assign {sq_own, sq_na, sq_nb, sq_nc} = sq_side;

  // The branch's own component is round(root / 2), saturated to one.
  logic [RTW:0]    root_p1;
  logic [RTW-1:0]  own_half;
  logic [QW-1:0]   own_val;
  assign root_p1  = {1'b0, sq_root} + {{RTW{1'b0}}, 1'b1};
  assign own_half = root_p1[RTW:1];
  assign own_val  = (own_half > ONE_RT) ? ONE_V : {1'b0, own_half[QW-2:0]};

  // Three division lanes in parallel; the own component waits alongside.
  logic                 dv_v_a, dv_v_b, dv_v_c;
  logic signed [QW-1:0] dv_qa, dv_qb, dv_qc;

  rmq_div #(.NUMW(NUMW), .RTW(RTW)) u_div_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (sq_v),
    .num_i   (sq_na),
    .root_i  (sq_root),
    .valid_o (dv_v_a),
    .q_o     (dv_qa)
  );

  rmq_div #(.NUMW(NUMW), .RTW(RTW)) u_div_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (sq_v),
    .num_i   (sq_nb),
    .root_i  (sq_root),
    .valid_o (dv_v_b),
    .q_o     (dv_qb)
  );

  rmq_div #(.NUMW(NUMW), .RTW(RTW)) u_div_c (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (sq_v),
    .num_i   (sq_nc),
    .root_i  (sq_root),
    .valid_o (dv_v_c),
    .q_o     (dv_qc)
  );

  logic [1:0]    own_dl_q [0:LAT-1];
  logic [QW-1:0] val_dl_q [0:LAT-1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      own_dl_q[0] <= sq_own;
      val_dl_q[0] <= own_val;
      for (int k = 1; k < LAT; k++) begin
        own_dl_q[k] <= own_dl_q[k-1];
        val_dl_q[k] <= val_dl_q[k-1];
      end
    end
  end

  // Put the lanes back in component order and make w non-negative.
  logic                 pipe_v;
  logic signed [QW-1:0] ow, w, x, y, z, nw;
  logic                 flip;
  quat_t                pipe_q;

  assign pipe_v = dv_v_a & dv_v_b & dv_v_c;
  assign ow     = $signed(val_dl_q[LAT-1]);

  always_comb begin
    unique case (own_dl_q[LAT-1])
      rmq_pkg::OWN_W: begin
        w = ow;    x = dv_qa; y = dv_qb; z = dv_qc;
      end
      rmq_pkg::OWN_X: begin
        w = dv_qa; x = ow;    y = dv_qb; z = dv_qc;
      end
      rmq_pkg::OWN_Y: begin
        w = dv_qa; x = dv_qb; y = ow;    z = dv_qc;
      end
      default: begin
        w = dv_qa; x = dv_qb; y = dv_qc; z = ow;
      end
    endcase
    flip      = w[QW-1];
    nw        = -w;
    pipe_q.qw = flip ? nw[rmq_pkg::QW_WIDTH-1:0] : w[rmq_pkg::QW_WIDTH-1:0];
    pipe_q.qx = flip ? -x : x;
    pipe_q.qy = flip ? -y : y;
    pipe_q.qz = flip ? -z : z;
  end

  // Output register with a one-beat skid register behind it.
  logic  out_v_q;
  quat_t out_q, skid_q;
  logic  out_free;
  assign out_free = !out_v_q || !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_free) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q  <= pipe_v;
      end
    end else if (adv && pipe_v) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_v_q ? skid_q : pipe_q;
    end else if (adv && pipe_v) begin
      skid_q <= pipe_q;
    end
  end

  assign valid_o = out_v_q;
  assign qw_o    = out_q.qw;
  assign qx_o    = out_q.qx;
  assign qy_o    = out_q.qy;
  assign qz_o    = out_q.qz;

endmodule

### tb/tb_rotation_matrix_to_quaternion.sv
`timescale 1ns / 1ps
// Self-checking testbench for rotation_matrix_to_quaternion: random and directed matrices,
// a fixed-point predictor of the four-case quaternion extraction, and a beat-by-beat check.
// Depends on rmq_pkg and the block under test; needs no files or arguments.

// Holds the quaternions still owed by the block, oldest first.
class quat_scoreboard;
  typedef struct packed {
    logic [rmq_pkg::QW_WIDTH-1:0]          qw;
    logic signed [rmq_pkg::QUAT_WIDTH-1:0] qx;
    logic signed [rmq_pkg::QUAT_WIDTH-1:0] qy;
    logic signed [rmq_pkg::QUAT_WIDTH-1:0] qz;
  } quat_t;

  quat_t pending_quats[$];
  int    mismatches;
  int    checked;
  int    branch_hits[4];

  function new();
    mismatches = 0;
    checked = 0;
    foreach (branch_hits[k]) branch_hits[k] = 0;
  endfunction

  // Integer square root, floor, by bit pairs.
  static function longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Rounded quotient, ties away from zero; clamping is left to clamp_one.
  static function longint scaled_div(longint num, longint unsigned den);
    longint unsigned mag;
    longint quo;
    mag = (num < 0) ? longint'(-num) : longint'(num);
    quo = longint'(((mag << rmq_pkg::FRAC_BITS) + den / 2) / den);
    return (num < 0) ? -quo : quo;
  endfunction

  static function longint clamp_one(longint v);
    if (v > rmq_pkg::ONE_Q) return rmq_pkg::ONE_Q;
    if (v < -rmq_pkg::ONE_Q) return -rmq_pkg::ONE_Q;
    return v;
  endfunction

  function void note_matrix(logic signed [15:0] m[9]);
    longint a00, a01, a02, a10, a11, a12, a20, a21, a22;
    longint trace, radicand;
    longint num[4];
    longint comp[4];
    logic [1:0] own;
    longint unsigned root;
    quat_t q;
    a00 = m[0]; a01 = m[1]; a02 = m[2];
    a10 = m[3]; a11 = m[4]; a12 = m[5];
    a20 = m[6]; a21 = m[7]; a22 = m[8];
    trace = a00 + a11 + a22;
    num = '{0, 0, 0, 0};
    if (trace > 0) begin
      own = rmq_pkg::OWN_W;
      radicand = trace + rmq_pkg::ONE_Q;
      num[1] = a21 - a12; num[2] = a02 - a20; num[3] = a10 - a01;
    end else if (a00 > a11 && a00 > a22) begin
      own = rmq_pkg::OWN_X;
      radicand = rmq_pkg::ONE_Q + a00 - a11 - a22;
      num[0] = a21 - a12; num[2] = a01 + a10; num[3] = a02 + a20;
    end else if (a11 > a22) begin
      own = rmq_pkg::OWN_Y;
      radicand = rmq_pkg::ONE_Q + a11 - a00 - a22;
      num[0] = a02 - a20; num[1] = a01 + a10; num[3] = a12 + a21;
    end else begin
      own = rmq_pkg::OWN_Z;
      radicand = rmq_pkg::ONE_Q + a22 - a00 - a11;
      num[0] = a10 - a01; num[1] = a02 + a20; num[2] = a12 + a21;
    end
    branch_hits[own]++;
    if (radicand < 1) radicand = 1;
    root = floor_sqrt(longint'(radicand) << rmq_pkg::FRAC_BITS);
    for (int k = 0; k < 4; k++) begin
      if (k == own) comp[k] = longint'((root + 1) >> 1);
      else comp[k] = scaled_div(num[k], 2 * root);
      comp[k] = clamp_one(comp[k]);
    end
    if (comp[0] < 0)
      for (int k = 0; k < 4; k++) comp[k] = -comp[k];
    q.qw = comp[0][rmq_pkg::QW_WIDTH-1:0];
    q.qx = comp[1][15:0];
    q.qy = comp[2][15:0];
    q.qz = comp[3][15:0];
    pending_quats.push_back(q);
  endfunction

  function void check_quat(quat_t got);
    quat_t want;
    checked++;
    if (pending_quats.size() == 0) begin
      $error("quaternion beat arrived with nothing outstanding");
      mismatches++;
      return;
    end
    want = pending_quats.pop_front();
    if (got.qw !== want.qw) begin
      $error("qw: expected %0d, got %0d", want.qw, got.qw); mismatches++;
    end
    if (got.qx !== want.qx) begin
      $error("qx: expected %0d, got %0d", want.qx, got.qx); mismatches++;
    end
    if (got.qy !== want.qy) begin
      $error("qy: expected %0d, got %0d", want.qy, got.qy); mismatches++;
    end
    if (got.qz !== want.qz) begin
      $error("qz: expected %0d, got %0d", want.qz, got.qz); mismatches++;
    end
  endfunction
endclass

module tb_rotation_matrix_to_quaternion;

  // The pipeline is 38 stages deep at the default width.
  localparam int PIPE_DEPTH = 38;
  localparam int RANDOM_ITEMS = 1250;
  // Cycles without any accepted beat before the run is abandoned; far above
  // the longest stall plus the full pipeline depth.
  localparam int IDLE_LIMIT = 5000;
  localparam logic signed [15:0] ONE_W = 16'sd16384;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_i = 1'b0;
  logic stall_o;
  logic valid_o;
  logic signed [15:0] m00_i = '0, m01_i = '0, m02_i = '0;
  logic signed [15:0] m10_i = '0, m11_i = '0, m12_i = '0;
  logic signed [15:0] m20_i = '0, m21_i = '0, m22_i = '0;
  logic [rmq_pkg::QW_WIDTH-1:0] qw_o;
  logic signed [rmq_pkg::QUAT_WIDTH-1:0] qx_o, qy_o, qz_o;

  quat_scoreboard quats;
  int idle_cycles = 0;
  bit out_ready = 1'b0;

  always #10 clk_i = ~clk_i;

  rotation_matrix_to_quaternion dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .valid_i(valid_i), .stall_o(stall_o),
    .m00_i(m00_i), .m01_i(m01_i), .m02_i(m02_i),
    .m10_i(m10_i), .m11_i(m11_i), .m12_i(m12_i),
    .m20_i(m20_i), .m21_i(m21_i), .m22_i(m22_i),
    .valid_o(valid_o), .stall_i(stall_i),
    .qw_o(qw_o), .qx_o(qx_o), .qy_o(qy_o), .qz_o(qz_o)
  );

  // Gap length: mostly none, otherwise a short one, now and then a long one.
  function automatic int gap_cycles();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // Presents one matrix and holds it until the block takes the beat.
  task automatic send_matrix(input logic signed [15:0] m[9], input bit with_gaps);
    int gap;
    gap = with_gaps ? gap_cycles() : 0;
    if (gap != 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    {m00_i, m01_i, m02_i} <= {m[0], m[1], m[2]};
    {m10_i, m11_i, m12_i} <= {m[3], m[4], m[5]};
    {m20_i, m21_i, m22_i} <= {m[6], m[7], m[8]};
    do @(posedge clk_i); while (stall_o);
    quats.note_matrix(m);
  endtask

  // A proper rotation about one axis, built from a random angle, with small noise.
  function automatic void rigid_matrix(output logic signed [15:0] m[9]);
    real ang, c, s;
    int axis;
    real r[9];
    ang = ($urandom_range(0, 65535) / 65535.0) * 6.2831853;
    c = $cos(ang);
    s = $sin(ang);
    axis = $urandom_range(0, 2);
    case (axis)
      0: r = '{1.0, 0.0, 0.0, 0.0, c, -s, 0.0, s, c};
      1: r = '{c, 0.0, s, 0.0, 1.0, 0.0, -s, 0.0, c};
      default: r = '{c, -s, 0.0, s, c, 0.0, 0.0, 0.0, 1.0};
    endcase
    // A random signed permutation keeps the matrix orthogonal and reaches every branch.
    if ($urandom_range(0, 1)) begin
      for (int k = 0; k < 3; k++) begin
        real t0;
        t0 = r[k]; r[k] = r[3 + k]; r[3 + k] = -t0;
      end
    end
    foreach (m[k]) m[k] = 16'(int'(r[k] * 16384.0) + $signed($urandom_range(0, 6)) - 3);
  endfunction

  // Output side: random stalls, and every beat checked as it is taken.
  initial begin
    int hold;
    @(posedge rst_ni);
    forever begin
      hold = out_ready ? 0 : gap_cycles();
      stall_i <= (hold != 0);
      if (hold != 0) begin
        repeat (hold) @(posedge clk_i);
        stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!valid_o);
      quats.check_quat('{qw_o, qx_o, qy_o, qz_o});
    end
  end

  // Watchdog on accepted beats in either direction.
  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic signed [15:0] m[9];
    quats = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed matrices: identity, half-turns about each axis (one per branch),
    // the most negative and most positive entries, an all-zero matrix, and a case
    // that gives a negative w to be flipped.
    m = '{ONE_W, 0, 0, 0, ONE_W, 0, 0, 0, ONE_W};           send_matrix(m, 0);
    m = '{ONE_W, 0, 0, 0, -ONE_W, 0, 0, 0, -ONE_W};         send_matrix(m, 0);
    m = '{-ONE_W, 0, 0, 0, ONE_W, 0, 0, 0, -ONE_W};         send_matrix(m, 0);
    m = '{-ONE_W, 0, 0, 0, -ONE_W, 0, 0, 0, ONE_W};         send_matrix(m, 0);
    m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                       send_matrix(m, 0);
    foreach (m[k]) m[k] = 16'sh8000;                        send_matrix(m, 0);
    foreach (m[k]) m[k] = 16'sh7FFF;                        send_matrix(m, 0);
    foreach (m[k]) m[k] = 16'shFFFF;                        send_matrix(m, 0);
    m = '{-ONE_W, 16'sh7FFF, 16'sh8000, 16'sh8000, -ONE_W, 16'sh7FFF,
          16'sh7FFF, 16'sh8000, -ONE_W};                    send_matrix(m, 0);
    m = '{ONE_W, 0, 0, 0, 0, ONE_W, 0, -ONE_W, 0};          send_matrix(m, 0);
    m = '{0, 0, 0, 0, 0, 0, 0, 16'sh8000, 16'sh0001};       send_matrix(m, 0);
    m = '{0, 16'sh5555, 16'shAAAA, 16'sh5555, 0, 16'shAAAA, 16'sh5555, 16'shAAAA, 0};
    send_matrix(m, 0);
    m = '{16'sh0001, 0, 0, 0, 16'sh0001, 0, 0, 0, 16'sh0001};
    send_matrix(m, 0);

    // Random part: mostly near-rigid rotations, the rest arbitrary bit patterns.
    // Some stretches run back to back, with the receiver never stalling.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      out_ready = ((i / 100) % 4 == 3);
      if ($urandom_range(0, 99) < 70) rigid_matrix(m);
      else foreach (m[k]) m[k] = 16'($urandom());
      send_matrix(m, !out_ready);
    end
    valid_i <= 1'b0;
    out_ready = 1'b0;

    while (quats.pending_quats.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 10) @(posedge clk_i);

    $display("Checked %0d quaternions; branch use w/x/y/z = %0d/%0d/%0d/%0d.",
             quats.checked, quats.branch_hits[0], quats.branch_hits[1],
             quats.branch_hits[2], quats.branch_hits[3]);
    if (quats.mismatches == 0 && quats.pending_quats.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
